// ----- hw/rtl/min_tracking_stack_macros.svh -----
// Assertion macros for the min tracking stack
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check sampled on the rising clock, off while reset is high
`define MTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Implication check, antecedent and consequent in the same cycle
`define MTS_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

`else

`define MTS_ASSERT(label, clk, rst, prop, msg)
`define MTS_ASSERT_IMP(label, clk, rst, cond, prop, msg)

`endif

`endif

// ----- hw/rtl/mts_pkg.sv -----
// Shared types and constants for the min tracking stack
package mts_pkg;

   localparam int DEFAULT_STACK_DEPTH = 64;
   localparam int DATA_WIDTH          = 32;
   localparam int KIND_WIDTH          = 2;

   // Value shown for top and minimum when the stack is empty
   localparam logic signed [DATA_WIDTH-1:0] EMPTY_READ = -32'sd1;

   // Operation codes; code 3 behaves as a peek
   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PUSH = 2'd0,
      KIND_POP  = 2'd1,
      KIND_PEEK = 2'd2
   } kind_type;

   // One stack entry: the value and the smallest value at or below it
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic signed [DATA_WIDTH-1:0] minimum;
   } entry_type;

   // Shift command broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

endpackage

// ----- hw/rtl/mts_ifs.sv -----
// Valid/ready channel interfaces for operation and result items
interface mts_req_if;
   logic                                       valid;
   logic                                       ready;
   logic [mts_pkg::KIND_WIDTH-1:0]             kind;
   logic signed [mts_pkg::DATA_WIDTH-1:0]      push_value;

   modport source (output valid, kind, push_value, input ready);
   modport sink   (input valid, kind, push_value, output ready);
endinterface

interface mts_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [mts_pkg::DATA_WIDTH-1:0]      top_value;
   logic signed [mts_pkg::DATA_WIDTH-1:0]      min_value;
   logic                                       is_empty;
   logic                                       push_dropped;

   modport source (output valid, top_value, min_value, is_empty, push_dropped, input ready);
   modport sink   (input valid, top_value, min_value, is_empty, push_dropped, output ready);
endinterface

// ----- hw/rtl/mts_cell.sv -----
// One stack slot: takes the entry above on push, the entry below on pop
module mts_cell (
   input  logic                clock,
   input  mts_pkg::shift_type  shift,
   input  mts_pkg::entry_type  from_above,
   input  mts_pkg::entry_type  from_below,
   output mts_pkg::entry_type  entry
);

   mts_pkg::entry_type entry_ff;
   mts_pkg::entry_type entry_in;

   // Next slot content
   always_comb begin
      entry_in = entry_ff;
      if (shift.push) begin
         entry_in = from_above;
      end else if (shift.pop) begin
         entry_in = from_below;
      end
   end

   // Payload only, no reset needed
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- hw/rtl/min_tracking_stack.sv -----
// Top level of the min tracking stack: cell chain, entry counter, result register
//
// LIFO stack of signed 32-bit values that also reports the running minimum. The
// stack is a row of STACK_DEPTH cells, cell 0 being the top; on a push every cell
// takes its upper neighbor's entry, on a pop its lower neighbor's, all in the same
// cycle. Each entry carries the minimum of itself and everything below it, so the
// minimum is always read from cell 0. Every operation item gives exactly one result
// item in the cycle after acceptance, held in an output register; an operation is
// taken every cycle while the result side keeps up (1 item per cycle). Top and
// minimum read -1 on an empty stack; a pop on an empty stack changes nothing, and a
// push onto a full stack is dropped and flagged with push_dropped. No clearing pass
// follows reset.
`include "min_tracking_stack_macros.svh"

module min_tracking_stack #(
   parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   mts_req_if.sink    req_port,
   mts_rsp_if.source  rsp_port
);

   localparam int                 CW          = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0]      DEPTH_COUNT = CW'(STACK_DEPTH);
   localparam logic [CW-1:0]      ONE_COUNT   = CW'(1);

   // Entry counter and result register
   logic [CW-1:0]                          count_ff, count_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [mts_pkg::DATA_WIDTH-1:0]  top_ff, top_in;
   logic signed [mts_pkg::DATA_WIDTH-1:0]  min_ff, min_in;
   logic                                   empty_ff, empty_in;
   logic                                   dropped_ff, dropped_in;

   logic                 accept;
   logic                 full;
   mts_pkg::kind_type    kind;
   mts_pkg::shift_type   shift;
   mts_pkg::entry_type   new_entry;
   mts_pkg::entry_type   cells [STACK_DEPTH];

   // Operation accepted whenever the result register is free or being drained
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;
   assign full           = (count_ff == DEPTH_COUNT);
   assign kind           = mts_pkg::kind_type'(req_port.kind);

   // Entry written at the top on push
   always_comb begin
      new_entry.value   = req_port.push_value;
      new_entry.minimum = req_port.push_value;
      if ((count_ff != '0) && (cells[0].minimum < req_port.push_value)) begin
         new_entry.minimum = cells[0].minimum;
      end
   end

   // Decode the operation into a shift command and drop flag
   always_comb begin
      shift.push = 1'b0;
      shift.pop  = 1'b0;
      dropped_in = 1'b0;
      unique case (kind)
         mts_pkg::KIND_PUSH: begin
            shift.push = accept && !full;
            dropped_in = full;
         end
         mts_pkg::KIND_POP: begin
            shift.pop = accept && (count_ff != '0);
         end
         default: begin
         end
      endcase
   end

   // Cell chain
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      mts_pkg::entry_type above;
      mts_pkg::entry_type below;
      if (i == 0) begin : g_top
         assign above = new_entry;
      end else begin : g_mid
         assign above = cells[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below = cells[i];
      end else begin : g_up
         assign below = cells[i+1];
      end
      mts_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_above (above),
         .from_below (below),
         .entry      (cells[i])
      );
   end

   // Count after the operation
   always_comb begin
      count_in = count_ff;
      if (shift.push) begin
         count_in = count_ff + ONE_COUNT;
      end else if (shift.pop) begin
         count_in = count_ff - ONE_COUNT;
      end
   end

   // Result as seen after the operation
   always_comb begin
      top_in   = cells[0].value;
      min_in   = cells[0].minimum;
      empty_in = (count_ff == '0);
      if (shift.push) begin
         top_in   = new_entry.value;
         min_in   = new_entry.minimum;
         empty_in = 1'b0;
      end else if (shift.pop) begin
         top_in   = cells[1].value;
         min_in   = cells[1].minimum;
         empty_in = (count_ff == ONE_COUNT);
      end
      if (empty_in) begin
         top_in = mts_pkg::EMPTY_READ;
         min_in = mts_pkg::EMPTY_READ;
      end
   end

   // Result valid handling
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         top_ff     <= top_in;
         min_ff     <= min_in;
         empty_ff   <= empty_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.top_value    = top_ff;
   assign rsp_port.min_value    = min_ff;
   assign rsp_port.is_empty     = empty_ff;
   assign rsp_port.push_dropped = dropped_ff;

   // Checks
   `MTS_ASSERT(a_count_bound, clock, reset, count_ff <= DEPTH_COUNT, "entry count above depth")
   `MTS_ASSERT_IMP(a_empty_reads, clock, reset, rsp_valid_ff && empty_ff, (top_ff == mts_pkg::EMPTY_READ) && (min_ff == mts_pkg::EMPTY_READ), "empty result must read -1")
   `MTS_ASSERT_IMP(a_empty_count, clock, reset, rsp_valid_ff, empty_ff == (count_ff == '0), "empty flag disagrees with count")
   `MTS_ASSERT_IMP(a_drop_full, clock, reset, rsp_valid_ff && dropped_ff, full, "push dropped while not full")
   `MTS_ASSERT_IMP(a_min_le_top, clock, reset, rsp_valid_ff && !empty_ff, min_ff <= top_ff, "minimum above top value")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for min_tracking_stack: directed and random stack operations
module testbench;

   localparam int DEPTH       = mts_pkg::DEFAULT_STACK_DEPTH;
   localparam int CYCLE_LIMIT = 200000;
   localparam int KIND_BITS   = mts_pkg::KIND_WIDTH;
   localparam int DATA_BITS   = mts_pkg::DATA_WIDTH;
   // Code 3 has no enum member; the block treats it as a peek
   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      logic signed [DATA_BITS-1:0] top_value;
      logic signed [DATA_BITS-1:0] min_value;
      logic                        is_empty;
      logic                        push_dropped;
   } stack_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mts_req_if req_if ();
   mts_rsp_if rsp_if ();

   min_tracking_stack #(
      .STACK_DEPTH (DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   // Shadow copy of the stack contents
   logic signed [DATA_BITS-1:0] shadow_values [DEPTH];
   logic signed [DATA_BITS-1:0] shadow_minima [DEPTH];
   int                          shadow_count;

   stack_view_type pending_views [$];

   int  error_count   = 0;
   int  cycle_count   = 0;
   int  ops_sent      = 0;
   int  results_seen  = 0;
   int  pushes_done   = 0;
   int  pushes_denied = 0;
   int  empty_pops    = 0;
   int  max_fill      = 0;
   bit  idle_on       = 1'b1;
   int  stall_left    = 0;

   // Clock
   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_views.size());
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_error(input string what);
      error_count++;
      $display("ERROR cycle %0d: %s", cycle_count, what);
   endtask

   // Apply one operation to the shadow stack and return the view it leaves
   function automatic stack_view_type apply_stack_op(
         input logic [KIND_BITS-1:0]        kind,
         input logic signed [DATA_BITS-1:0] value);
      stack_view_type view;
      logic signed [DATA_BITS-1:0] new_min;
      view.push_dropped = 1'b0;
      if (kind == mts_pkg::KIND_PUSH) begin
         if (shadow_count >= DEPTH) begin
            view.push_dropped = 1'b1;
            pushes_denied++;
         end else begin
            new_min = value;
            if (shadow_count > 0 && shadow_minima[shadow_count-1] < value)
               new_min = shadow_minima[shadow_count-1];
            shadow_values[shadow_count] = value;
            shadow_minima[shadow_count] = new_min;
            shadow_count++;
            pushes_done++;
         end
      end else if (kind == mts_pkg::KIND_POP) begin
         if (shadow_count > 0) shadow_count--;
         else empty_pops++;
      end
      if (shadow_count > max_fill) max_fill = shadow_count;
      if (shadow_count == 0) begin
         view.top_value = mts_pkg::EMPTY_READ;
         view.min_value = mts_pkg::EMPTY_READ;
         view.is_empty  = 1'b1;
      end else begin
         view.top_value = shadow_values[shadow_count-1];
         view.min_value = shadow_minima[shadow_count-1];
         view.is_empty  = 1'b0;
      end
      return view;
   endfunction

   // Drive one operation item, with an optional idle burst before it
   task automatic send_op(input logic [KIND_BITS-1:0] kind,
                          input logic signed [DATA_BITS-1:0] value);
      int gap;
      stack_view_type view;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.kind       <= kind;
      req_if.push_value <= value;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      view = apply_stack_op(kind, value);
      pending_views = {pending_views, view};
      ops_sent++;
   endtask

   // Values weighted toward the extremes and small numbers
   function automatic logic signed [DATA_BITS-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return -32'sd1;
         3:       return 32'sd0;
         4:       return $signed($urandom_range(0, 20)) - 32'sd10;
         default: return $signed($urandom);
      endcase
   endfunction

   // Result side: random stall bursts while idling is on
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 7) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      stack_view_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         results_seen++;
         if (pending_views.size() == 0) begin
            report_error("result with no operation outstanding");
         end else begin
            want = pending_views.pop_front();
            if (rsp_if.top_value !== want.top_value)
               report_error($sformatf("top_value got %0d want %0d",
                                      rsp_if.top_value, want.top_value));
            if (rsp_if.min_value !== want.min_value)
               report_error($sformatf("min_value got %0d want %0d",
                                      rsp_if.min_value, want.min_value));
            if (rsp_if.is_empty !== want.is_empty)
               report_error($sformatf("is_empty got %b want %b",
                                      rsp_if.is_empty, want.is_empty));
            if (rsp_if.push_dropped !== want.push_dropped)
               report_error($sformatf("push_dropped got %b want %b",
                                      rsp_if.push_dropped, want.push_dropped));
         end
      end
   end

   // Operations on an empty stack, and a pushed -1 that looks like empty
   task automatic test_empty_stack();
      send_op(mts_pkg::KIND_POP, 32'sd5);
      send_op(mts_pkg::KIND_PEEK, 32'sd0);
      send_op(KIND_UNUSED, -32'sd1);
      send_op(mts_pkg::KIND_PUSH, -32'sd1);
      send_op(mts_pkg::KIND_PEEK, 32'sh7FFF_FFFF);
      send_op(mts_pkg::KIND_POP, 32'sh8000_0000);
      send_op(mts_pkg::KIND_POP, 32'sd0);
   endtask

   // Largest and smallest values; minimum must hold across larger pushes
   task automatic test_extreme_values();
      send_op(mts_pkg::KIND_PUSH, 32'sh7FFF_FFFF);
      send_op(mts_pkg::KIND_PUSH, 32'sh8000_0000);
      send_op(mts_pkg::KIND_PUSH, 32'sh7FFF_FFFF);
      send_op(mts_pkg::KIND_PUSH, 32'sd0);
      send_op(mts_pkg::KIND_PEEK, -32'sd1);
      send_op(KIND_UNUSED, 32'sd0);
      repeat (4) send_op(mts_pkg::KIND_POP, -32'sd1);
      send_op(mts_pkg::KIND_POP, 32'sh7FFF_FFFF);
   endtask

   // Fill past the top with random content, then drain with pops and occasional peeks
   task automatic test_fill_and_drain(input int rounds);
      int order;
      logic signed [DATA_BITS-1:0] val;
      for (int r = 0; r < rounds; r++) begin
         order = $urandom_range(0, 2);
         val   = (order == 1) ? 32'sh7FFF_FFF0 : 32'sh8000_0010;
         for (int i = 0; i < DEPTH + 3; i++) begin
            // descending, ascending or random runs exercise the minimum update
            case (order)
               1:       val = val - $signed(DATA_BITS'($urandom_range(0, 1000)));
               2:       val = val + $signed(DATA_BITS'($urandom_range(0, 1000)));
               default: val = pick_value();
            endcase
            send_op(mts_pkg::KIND_PUSH, val);
         end
         send_op(mts_pkg::KIND_PEEK, pick_value());
         for (int i = 0; i < DEPTH + 2; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_op(KIND_BITS'($urandom_range(2, 3)), pick_value());
            else send_op(mts_pkg::KIND_POP, pick_value());
         end
      end
   endtask

   // Random operation mix with a push bias that moves between phases
   task automatic test_random_mix(input int count);
      int r;
      int push_weight;
      logic [KIND_BITS-1:0] kind;
      push_weight = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) push_weight = 30 + 20 * $urandom_range(0, 2);
         r = $urandom_range(0, 99);
         if (r < push_weight) kind = mts_pkg::KIND_PUSH;
         else if (r < 85) kind = mts_pkg::KIND_POP;
         else kind = KIND_BITS'($urandom_range(2, 3));
         send_op(kind, pick_value());
      end
   endtask

   // Back-to-back items with the result side always ready
   task automatic test_full_rate(input int count);
      idle_on = 1'b0;
      test_random_mix(count);
   endtask

   initial begin
      req_if.valid      = 1'b0;
      req_if.kind       = mts_pkg::KIND_PEEK;
      req_if.push_value = '0;
      shadow_count      = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_stack();
      test_extreme_values();
      test_fill_and_drain(2);
      test_random_mix(300);
      test_full_rate(80);

      req_if.valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("%0d operations, %0d results: %0d pushes, %0d dropped on full, %0d empty pops",
               ops_sent, results_seen, pushes_done, pushes_denied, empty_pops);
      $display("deepest fill %0d of %0d entries, %0d mismatches", max_fill, DEPTH, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mts_pkg.sv
hw/rtl/mts_ifs.sv
hw/rtl/mts_cell.sv
hw/rtl/min_tracking_stack.sv
dv/testbench.sv
